FILE: hdl/assert_macros.svh
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// check that a condition holds at every clock edge out of reset
`define CDF_ASSERT(lbl, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond)) else $error(msg);

// check that a trigger implies a condition in the same cycle
`define CDF_ASSERT_IMP(lbl, trig, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (trig) |-> (cond)) else $error(msg);

`endif

FILE: hdl/cdfu_pkg.sv
`timescale 1ns / 1ps
package cdfu_pkg;
  localparam int MAX_ROWS       = 64;
  localparam int MAX_COLS       = 64;
  localparam int HISTORY_FRAMES = 32;
  localparam int COLOR_BITS     = 8;

  localparam int ROW_W       = $clog2(MAX_ROWS);
  localparam int COL_W       = $clog2(MAX_COLS);
  localparam int CELL_W      = ROW_W + COL_W;
  localparam int SWEEP       = 2 ** CELL_W;
  localparam int FRM_W       = $clog2(HISTORY_FRAMES);
  localparam int USED_W      = $clog2(HISTORY_FRAMES + 1);
  localparam int FADDR_W     = FRM_W + CELL_W;
  localparam int FRAME_DEPTH = 2 ** FADDR_W;
  localparam int TOP_W       = CELL_W + 1;

  localparam int REQ_W     = 3;
  localparam int COORD_W   = 6;
  localparam int COLOR_W   = 8;
  localparam int STATUS_W  = 2;
  localparam int CFG_W     = 7;
  localparam int CFG_IDX_W = 2;

  typedef enum logic [REQ_W-1:0] {
    REQ_DOT  = 3'd0,
    REQ_RECT = 3'd1,
    REQ_FILL = 3'd2,
    REQ_UNDO = 3'd3,
    REQ_REDO = 3'd4,
    REQ_READ = 3'd5
  } req_t;

  localparam logic [STATUS_W-1:0] ST_DONE  = 2'd0;
  localparam logic [STATUS_W-1:0] ST_RANGE = 2'd1;
  localparam logic [STATUS_W-1:0] ST_FULL  = 2'd2;

  localparam logic [CFG_IDX_W-1:0] CFG_ROWS = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_COLS = 2'd1;

  typedef enum logic [3:0] {
    S_IDLE,
    S_DECODE,
    S_RD_DATA,
    S_COPY,
    S_FL_START,
    S_FL_POP_RD,
    S_FL_POP_WT,
    S_FL_NB_RD,
    S_FL_NB_CHK,
    S_RESP
  } state_t;
endpackage

FILE: hdl/cdfu_in_if.sv
`timescale 1ns / 1ps
interface cdfu_in_if import cdfu_pkg::*; ();
  logic                 valid;
  logic                 ready;
  logic [REQ_W-1:0]     req_type;
  logic [COORD_W-1:0]   row_a;
  logic [COORD_W-1:0]   col_a;
  logic [COORD_W-1:0]   row_b;
  logic [COORD_W-1:0]   col_b;
  logic [COLOR_W-1:0]   color;
  modport source (output valid, req_type, row_a, col_a, row_b, col_b, color, input ready);
  modport sink (input valid, req_type, row_a, col_a, row_b, col_b, color, output ready);
endinterface

FILE: hdl/cdfu_out_if.sv
`timescale 1ns / 1ps
interface cdfu_out_if import cdfu_pkg::*; ();
  logic                valid;
  logic                ready;
  logic [STATUS_W-1:0] status;
  logic [COLOR_W-1:0]  read_color;
  modport source (output valid, status, read_color, input ready);
  modport sink (input valid, status, read_color, output ready);
endinterface

FILE: hdl/cdfu_cfg_if.sv
`timescale 1ns / 1ps
interface cdfu_cfg_if import cdfu_pkg::*; ();
  logic                 valid;
  logic                 ready;
  logic [CFG_IDX_W-1:0] index;
  logic [CFG_W-1:0]     data;
  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

FILE: hdl/cdfu_ram.sv
`timescale 1ns / 1ps
module cdfu_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule

FILE: hdl/canvas_draw_fill_undo_engine.sv
`timescale 1ns / 1ps
// Read, undo and redo make no copy; dot, rectangle and fill first copy the full current frame.
// Flood fill then paints cell by cell after the copy, bound by the frame memory port.
// One request in flight at a time; the next is taken once the result is in the output register.
// Reset (synchronous, active low) makes frame 0 current and blank with no clearing pass:
// frame 0 is never written and always reads as zero. Counts reset to 64 rows and 64 columns.
`include "assert_macros.svh"
module canvas_draw_fill_undo_engine import cdfu_pkg::*; (
  input logic        clk,
  input logic        rst_n,
  cdfu_in_if.sink    in_ch,
  cdfu_out_if.source out_ch,
  cdfu_cfg_if.sink   cfg_ch
);
  state_t state_r, state_nxt;

  logic [REQ_W-1:0]      req_r, req_nxt;
  logic [ROW_W-1:0]      ra_r, ra_nxt, rb_r, rb_nxt;
  logic [COL_W-1:0]      ca_r, ca_nxt, cb_r, cb_nxt;
  logic [COLOR_BITS-1:0] col_r, col_nxt, old_r, old_nxt;
  logic [CFG_W-1:0]      rows_r, cols_r;
  logic [USED_W-1:0]     used_r, used_nxt;
  logic [FRM_W-1:0]      cur_r, cur_nxt, src_r, src_nxt, dst_r, dst_nxt;
  logic [CELL_W:0]       idx_r, idx_nxt;
  logic [CELL_W-1:0]     pidx_r, pidx_nxt;
  logic                  pvld_r, pvld_nxt;
  logic [TOP_W-1:0]      top_r, top_nxt;
  logic [ROW_W-1:0]      cr_r, cr_nxt;
  logic [COL_W-1:0]      cc_r, cc_nxt;
  logic [1:0]            nb_r, nb_nxt;
  logic [STATUS_W-1:0]   res_st_r, res_st_nxt;
  logic [COLOR_W-1:0]    res_rd_r, res_rd_nxt;
  logic                  out_valid_r, out_valid_nxt;
  logic [STATUS_W-1:0]   out_st_r, out_st_nxt;
  logic [COLOR_W-1:0]    out_rd_r, out_rd_nxt;

  logic                  fr_we;
  logic [FADDR_W-1:0]    fr_waddr, fr_raddr;
  logic [COLOR_BITS-1:0] fr_wdata, fr_rdata;
  logic                  st_we;
  logic [CELL_W-1:0]     st_waddr, st_raddr, st_wdata, st_rdata;

  logic [CFG_W-1:0]      rows_use, cols_use;
  logic                  bad, hit, nb_ok, load_out, in_xfer;
  logic [ROW_W-1:0]      r1, r2, pr, nr;
  logic [COL_W-1:0]      c1, c2, pc, nc;
  logic [COLOR_BITS-1:0] src_data;

  cdfu_ram #(.WIDTH(COLOR_BITS), .DEPTH(FRAME_DEPTH)) u_frames (
    .clk(clk), .we(fr_we), .waddr(fr_waddr), .wdata(fr_wdata),
    .raddr(fr_raddr), .rdata(fr_rdata)
  );

  cdfu_ram #(.WIDTH(CELL_W), .DEPTH(SWEEP)) u_stack (
    .clk(clk), .we(st_we), .waddr(st_waddr), .wdata(st_wdata),
    .raddr(st_raddr), .rdata(st_rdata)
  );

  assign in_ch.ready       = (state_r == S_IDLE);
  assign in_xfer           = in_ch.valid && in_ch.ready;
  assign cfg_ch.ready      = 1'b1;
  assign out_ch.valid      = out_valid_r;
  assign out_ch.status     = out_st_r;
  assign out_ch.read_color = out_rd_r;

  always_comb begin
    if (rows_r == '0) rows_use = CFG_W'(1);
    else if (rows_r > CFG_W'(MAX_ROWS)) rows_use = CFG_W'(MAX_ROWS);
    else rows_use = rows_r;
    if (cols_r == '0) cols_use = CFG_W'(1);
    else if (cols_r > CFG_W'(MAX_COLS)) cols_use = CFG_W'(MAX_COLS);
    else cols_use = cols_r;
  end

  always_comb begin
    bad = (CFG_W'(ra_r) >= rows_use) || (CFG_W'(ca_r) >= cols_use);
    if (req_r == REQ_RECT && ((CFG_W'(rb_r) >= rows_use) || (CFG_W'(cb_r) >= cols_use))) begin
      bad = 1'b1;
    end
    r1 = (ra_r < rb_r) ? ra_r : rb_r;
    r2 = (ra_r < rb_r) ? rb_r : ra_r;
    c1 = (ca_r < cb_r) ? ca_r : cb_r;
    c2 = (ca_r < cb_r) ? cb_r : ca_r;
    pr = pidx_r[CELL_W-1:COL_W];
    pc = pidx_r[COL_W-1:0];
    case (req_r)
      REQ_DOT:  hit = (pr == ra_r) && (pc == ca_r);
      REQ_RECT: hit = (((pr == r1) || (pr == r2)) && (pc >= c1) && (pc <= c2)) ||
                      (((pc == c1) || (pc == c2)) && (pr >= r1) && (pr <= r2));
      default:  hit = 1'b0;
    endcase
    src_data = (src_r == '0) ? '0 : fr_rdata;
  end

  always_comb begin
    nr = cr_r;
    nc = cc_r;
    case (nb_r)
      2'd0: begin
        nb_ok = (cr_r != '0);
        nr    = cr_r - ROW_W'(1);
      end
      2'd1: begin
        nb_ok = (CFG_W'(cr_r) + CFG_W'(1)) < rows_use;
        nr    = cr_r + ROW_W'(1);
      end
      2'd2: begin
        nb_ok = (cc_r != '0);
        nc    = cc_r - COL_W'(1);
      end
      default: begin
        nb_ok = (CFG_W'(cc_r) + CFG_W'(1)) < cols_use;
        nc    = cc_r + COL_W'(1);
      end
    endcase
  end

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE:   if (in_xfer) state_nxt = S_DECODE;
      S_DECODE: begin
        state_nxt = S_RESP;
        if (!bad && req_r == REQ_READ && cur_r != '0) begin
          state_nxt = S_RD_DATA;
        end else if (!bad && (req_r == REQ_DOT || req_r == REQ_RECT || req_r == REQ_FILL) &&
                     used_r < USED_W'(HISTORY_FRAMES)) begin
          state_nxt = S_COPY;
        end
      end
      S_RD_DATA: state_nxt = S_RESP;
      S_COPY: begin
        if (idx_r == (CELL_W+1)'(SWEEP)) begin
          state_nxt = (req_r == REQ_FILL) ? S_FL_START : S_RESP;
        end
      end
      S_FL_START:  state_nxt = (old_r == col_r) ? S_RESP : S_FL_POP_RD;
      S_FL_POP_RD: state_nxt = (top_r == '0) ? S_RESP : S_FL_POP_WT;
      S_FL_POP_WT: state_nxt = S_FL_NB_RD;
      S_FL_NB_RD: begin
        if (nb_ok) state_nxt = S_FL_NB_CHK;
        else if (nb_r == 2'd3) state_nxt = S_FL_POP_RD;
      end
      S_FL_NB_CHK: state_nxt = (nb_r == 2'd3) ? S_FL_POP_RD : S_FL_NB_RD;
      S_RESP:      if (!out_valid_r || out_ch.ready) state_nxt = S_IDLE;
      default:     state_nxt = S_IDLE;
    endcase
  end

  always_comb begin
    req_nxt    = req_r;
    ra_nxt     = ra_r;
    ca_nxt     = ca_r;
    rb_nxt     = rb_r;
    cb_nxt     = cb_r;
    col_nxt    = col_r;
    old_nxt    = old_r;
    used_nxt   = used_r;
    cur_nxt    = cur_r;
    src_nxt    = src_r;
    dst_nxt    = dst_r;
    idx_nxt    = idx_r;
    pidx_nxt   = pidx_r;
    pvld_nxt   = 1'b0;
    top_nxt    = top_r;
    cr_nxt     = cr_r;
    cc_nxt     = cc_r;
    nb_nxt     = nb_r;
    res_st_nxt = res_st_r;
    res_rd_nxt = res_rd_r;
    fr_we      = 1'b0;
    fr_waddr   = {dst_r, pidx_r};
    fr_wdata   = hit ? col_r : src_data;
    fr_raddr   = {src_r, idx_r[CELL_W-1:0]};
    st_we      = 1'b0;
    st_waddr   = top_r[CELL_W-1:0];
    st_wdata   = {nr, nc};
    st_raddr   = top_r[CELL_W-1:0] - CELL_W'(1);
    load_out   = 1'b0;

    case (state_r)
      S_IDLE: begin
        if (in_xfer) begin
          req_nxt = in_ch.req_type;
          ra_nxt  = ROW_W'(in_ch.row_a);
          ca_nxt  = COL_W'(in_ch.col_a);
          rb_nxt  = ROW_W'(in_ch.row_b);
          cb_nxt  = COL_W'(in_ch.col_b);
          col_nxt = COLOR_BITS'(in_ch.color);
        end
      end
      S_DECODE: begin
        res_st_nxt = ST_DONE;
        res_rd_nxt = '0;
        fr_raddr   = {cur_r, ra_r, ca_r};
        case (req_r)
          REQ_DOT, REQ_RECT, REQ_FILL: begin
            if (bad) begin
              res_st_nxt = ST_RANGE;
            end else if (used_r >= USED_W'(HISTORY_FRAMES)) begin
              res_st_nxt = ST_FULL;
            end else begin
              src_nxt  = cur_r;
              dst_nxt  = FRM_W'(used_r);
              cur_nxt  = FRM_W'(used_r);
              used_nxt = used_r + USED_W'(1);
              idx_nxt  = '0;
            end
          end
          REQ_READ: if (bad) res_st_nxt = ST_RANGE;
          REQ_UNDO: if (cur_r != '0) cur_nxt = cur_r - FRM_W'(1);
          REQ_REDO: if (USED_W'(cur_r) + USED_W'(1) < used_r) cur_nxt = cur_r + FRM_W'(1);
          default: ;
        endcase
      end
      S_RD_DATA: res_rd_nxt = COLOR_W'(fr_rdata);
      S_COPY: begin
        fr_we = pvld_r;
        if (pvld_r && pidx_r == {ra_r, ca_r}) old_nxt = src_data;
        if (idx_r != (CELL_W+1)'(SWEEP)) begin
          pidx_nxt = idx_r[CELL_W-1:0];
          pvld_nxt = 1'b1;
          idx_nxt  = idx_r + (CELL_W+1)'(1);
        end
      end
      S_FL_START: begin
        fr_waddr = {dst_r, ra_r, ca_r};
        fr_wdata = col_r;
        st_waddr = '0;
        st_wdata = {ra_r, ca_r};
        if (old_r != col_r) begin
          fr_we   = 1'b1;
          st_we   = 1'b1;
          top_nxt = TOP_W'(1);
        end
      end
      S_FL_POP_RD: if (top_r != '0) top_nxt = top_r - TOP_W'(1);
      S_FL_POP_WT: begin
        cr_nxt = st_rdata[CELL_W-1:COL_W];
        cc_nxt = st_rdata[COL_W-1:0];
        nb_nxt = 2'd0;
      end
      S_FL_NB_RD: begin
        fr_raddr = {dst_r, nr, nc};
        if (!nb_ok) nb_nxt = nb_r + 2'd1;
      end
      S_FL_NB_CHK: begin
        fr_waddr = {dst_r, nr, nc};
        fr_wdata = col_r;
        if (fr_rdata == old_r) begin
          fr_we = 1'b1;
          if (top_r < TOP_W'(SWEEP)) begin
            st_we   = 1'b1;
            top_nxt = top_r + TOP_W'(1);
          end
        end
        nb_nxt = nb_r + 2'd1;
      end
      S_RESP:  load_out = !out_valid_r || out_ch.ready;
      default: ;
    endcase

    out_valid_nxt = (out_valid_r && !out_ch.ready) || load_out;
    out_st_nxt    = load_out ? res_st_r : out_st_r;
    out_rd_nxt    = load_out ? res_rd_r : out_rd_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      used_r      <= USED_W'(1);
      cur_r       <= '0;
      top_r       <= '0;
      pvld_r      <= 1'b0;
      out_valid_r <= 1'b0;
      rows_r      <= CFG_W'(64);
      cols_r      <= CFG_W'(64);
    end else begin
      state_r     <= state_nxt;
      used_r      <= used_nxt;
      cur_r       <= cur_nxt;
      top_r       <= top_nxt;
      pvld_r      <= pvld_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_ch.valid && cfg_ch.ready) begin
        if (cfg_ch.index == CFG_ROWS) rows_r <= cfg_ch.data;
        if (cfg_ch.index == CFG_COLS) cols_r <= cfg_ch.data;
      end
    end
  end

  always_ff @(posedge clk) begin
    req_r    <= req_nxt;
    ra_r     <= ra_nxt;
    ca_r     <= ca_nxt;
    rb_r     <= rb_nxt;
    cb_r     <= cb_nxt;
    col_r    <= col_nxt;
    old_r    <= old_nxt;
    src_r    <= src_nxt;
    dst_r    <= dst_nxt;
    idx_r    <= idx_nxt;
    pidx_r   <= pidx_nxt;
    cr_r     <= cr_nxt;
    cc_r     <= cc_nxt;
    nb_r     <= nb_nxt;
    res_st_r <= res_st_nxt;
    res_rd_r <= res_rd_nxt;
    out_st_r <= out_st_nxt;
    out_rd_r <= out_rd_nxt;
  end

  `CDF_ASSERT(a_cur_below_used, USED_W'(cur_r) < used_r, "current frame beyond history")
  `CDF_ASSERT(a_used_bound, used_r <= USED_W'(HISTORY_FRAMES), "history count overflow")
  `CDF_ASSERT_IMP(a_no_frame0_write, fr_we, fr_waddr[FADDR_W-1:CELL_W] != '0, "frame 0 written")
  `CDF_ASSERT(a_stack_bound, top_r <= TOP_W'(SWEEP), "fill stack overflow")
endmodule

FILE: sim/tb_canvas_draw_fill_undo_engine.sv
`timescale 1ns / 1ps
module tb_canvas_draw_fill_undo_engine;
  import cdfu_pkg::*;

  localparam int CELLS      = MAX_ROWS * MAX_COLS;
  localparam int IDLE_LIMIT = 400000;
  localparam logic [REQ_W-1:0] REQ_SPARE_6 = 3'd6;
  localparam logic [REQ_W-1:0] REQ_SPARE_7 = 3'd7;

  typedef struct packed {
    logic [REQ_W-1:0]   req;
    logic [COORD_W-1:0] ra;
    logic [COORD_W-1:0] ca;
    logic [COORD_W-1:0] rb;
    logic [COORD_W-1:0] cb;
    logic [COLOR_W-1:0] color;
  } canvas_cmd_t;

  typedef struct packed {
    logic [STATUS_W-1:0] status;
    logic [COLOR_W-1:0]  read_color;
  } canvas_reply_t;

  class canvas_tracker;
    logic [COLOR_W-1:0] frames [HISTORY_FRAMES][CELLS];
    int unsigned frames_used;
    int unsigned cur_frame;
    int unsigned cfg_rows;
    int unsigned cfg_cols;
    int unsigned fill_stack [$];
    canvas_reply_t pending_replies [$];
    int unsigned mismatches;
    int unsigned n_done, n_range, n_full, n_reads, n_fills;

    function new();
      foreach (frames[f, i]) frames[f][i] = '0;
      frames_used = 1;
      cur_frame   = 0;
      cfg_rows    = 64;
      cfg_cols    = 64;
    endfunction

    function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_W-1:0] val);
      if (idx == CFG_ROWS) cfg_rows = val;
      else if (idx == CFG_COLS) cfg_cols = val;
    endfunction

    function int unsigned rows_used();
      if (cfg_rows == 0) return 1;
      if (cfg_rows > MAX_ROWS) return MAX_ROWS;
      return cfg_rows;
    endfunction

    function int unsigned cols_used();
      if (cfg_cols == 0) return 1;
      if (cfg_cols > MAX_COLS) return MAX_COLS;
      return cfg_cols;
    endfunction

    function void paint_push(int unsigned f, int unsigned r, int unsigned c,
                             logic [COLOR_W-1:0] col);
      frames[f][r * MAX_COLS + c] = col;
      fill_stack.push_back(r * MAX_COLS + c);
    endfunction

    function void flood(int unsigned f, int unsigned r0, int unsigned c0,
                        logic [COLOR_W-1:0] col, int unsigned rows, int unsigned cols);
      logic [COLOR_W-1:0] old;
      int unsigned e, r, c;
      old = frames[f][r0 * MAX_COLS + c0];
      if (old == col) return;
      fill_stack.delete();
      paint_push(f, r0, c0, col);
      while (fill_stack.size() > 0) begin
        e = fill_stack.pop_back();
        r = e / MAX_COLS;
        c = e % MAX_COLS;
        if (r > 0 && frames[f][(r - 1) * MAX_COLS + c] == old) paint_push(f, r - 1, c, col);
        if (r + 1 < rows && frames[f][(r + 1) * MAX_COLS + c] == old)
          paint_push(f, r + 1, c, col);
        if (c > 0 && frames[f][r * MAX_COLS + c - 1] == old) paint_push(f, r, c - 1, col);
        if (c + 1 < cols && frames[f][r * MAX_COLS + c + 1] == old)
          paint_push(f, r, c + 1, col);
      end
    endfunction

    function void note_request(canvas_cmd_t cmd);
      canvas_reply_t rep;
      int unsigned rows, cols, nf, r1, r2, c1, c2;
      bit bad;
      rows = rows_used();
      cols = cols_used();
      rep  = '0;
      rep.status = ST_DONE;
      if (cmd.req <= REQ_FILL || cmd.req == REQ_READ) begin
        bad = (cmd.ra >= rows) || (cmd.ca >= cols);
        if (cmd.req == REQ_RECT && (cmd.rb >= rows || cmd.cb >= cols)) bad = 1;
        if (bad) begin
          rep.status = ST_RANGE;
        end else if (cmd.req == REQ_READ) begin
          rep.read_color = frames[cur_frame][cmd.ra * MAX_COLS + cmd.ca];
          n_reads++;
        end else if (frames_used >= HISTORY_FRAMES) begin
          rep.status = ST_FULL;
        end else begin
          nf = frames_used;
          frames[nf] = frames[cur_frame];
          cur_frame   = nf;
          frames_used = nf + 1;
          if (cmd.req == REQ_DOT) begin
            frames[nf][cmd.ra * MAX_COLS + cmd.ca] = cmd.color;
          end else if (cmd.req == REQ_RECT) begin
            r1 = cmd.ra < cmd.rb ? cmd.ra : cmd.rb;
            r2 = cmd.ra < cmd.rb ? cmd.rb : cmd.ra;
            c1 = cmd.ca < cmd.cb ? cmd.ca : cmd.cb;
            c2 = cmd.ca < cmd.cb ? cmd.cb : cmd.ca;
            for (int unsigned i = c1; i <= c2; i++) begin
              frames[nf][r1 * MAX_COLS + i] = cmd.color;
              frames[nf][r2 * MAX_COLS + i] = cmd.color;
            end
            for (int unsigned i = r1; i <= r2; i++) begin
              frames[nf][i * MAX_COLS + c1] = cmd.color;
              frames[nf][i * MAX_COLS + c2] = cmd.color;
            end
          end else begin
            flood(nf, cmd.ra, cmd.ca, cmd.color, rows, cols);
            n_fills++;
          end
        end
      end else if (cmd.req == REQ_UNDO) begin
        if (cur_frame > 0) cur_frame--;
      end else if (cmd.req == REQ_REDO) begin
        if (cur_frame + 1 < frames_used) cur_frame++;
      end
      case (rep.status)
        ST_RANGE: n_range++;
        ST_FULL:  n_full++;
        default:  n_done++;
      endcase
      pending_replies.push_back(rep);
    endfunction

    function void check_reply(logic [STATUS_W-1:0] status, logic [COLOR_W-1:0] rd);
      canvas_reply_t exp_rep;
      if (pending_replies.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("unexpected reply: status %0d read_color %0d", status, rd);
        return;
      end
      exp_rep = pending_replies.pop_front();
      if (status !== exp_rep.status || rd !== exp_rep.read_color) begin
        mismatches++;
        if (mismatches <= 10)
          $display("reply mismatch: expected status %0d read_color %0d, got %0d %0d",
                   exp_rep.status, exp_rep.read_color, status, rd);
      end
    endfunction
  endclass

  logic clk;
  logic rst_n;
  bit   no_idle;
  int unsigned idle_cycles;
  canvas_tracker sb = new();

  cdfu_in_if  in_ch ();
  cdfu_out_if out_ch ();
  cdfu_cfg_if cfg_ch ();

  canvas_draw_fill_undo_engine DUT (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch),
    .cfg_ch (cfg_ch)
  );

  initial clk = 1'b0;
  always #1 clk = ~clk;

  initial begin
    rst_n        <= 1'b0;
    in_ch.valid  <= 1'b0;
    in_ch.req_type <= '0;
    in_ch.row_a  <= '0;
    in_ch.col_a  <= '0;
    in_ch.row_b  <= '0;
    in_ch.col_b  <= '0;
    in_ch.color  <= '0;
    cfg_ch.valid <= 1'b0;
    cfg_ch.index <= '0;
    cfg_ch.data  <= '0;
    out_ch.ready <= 1'b0;
  end

  always @(posedge clk) begin
    if (rst_n) begin
      if (in_ch.valid && in_ch.ready)
        sb.note_request({in_ch.req_type, in_ch.row_a, in_ch.col_a, in_ch.row_b,
                         in_ch.col_b, in_ch.color});
      if (out_ch.valid && out_ch.ready) sb.check_reply(out_ch.status, out_ch.read_color);
      if (cfg_ch.valid && cfg_ch.ready) sb.write_reg(cfg_ch.index, cfg_ch.data);
      if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready) ||
          (cfg_ch.valid && cfg_ch.ready)) begin
        idle_cycles <= 0;
      end else if (idle_cycles >= IDLE_LIMIT) begin
        $display("watchdog: no transfer for %0d cycles", IDLE_LIMIT);
        $display("Regression FAIL");
        $finish;
      end else begin
        idle_cycles <= idle_cycles + 1;
      end
    end else begin
      idle_cycles <= 0;
    end
  end

  initial begin
    @(posedge clk);
    while (!rst_n) @(posedge clk);
    forever begin
      out_ch.ready <= 1'b1;
      repeat ($urandom_range(1, 20)) @(posedge clk);
      if (!no_idle) begin
        out_ch.ready <= 1'b0;
        repeat ($urandom_range(1, 8)) @(posedge clk);
      end
    end
  end

  task automatic send_cmd(canvas_cmd_t cmd);
    if (!no_idle && $urandom_range(0, 2) == 0) begin
      in_ch.valid <= 1'b0;
      repeat ($urandom_range(1, 8)) @(posedge clk);
    end
    in_ch.valid    <= 1'b1;
    in_ch.req_type <= cmd.req;
    in_ch.row_a    <= cmd.ra;
    in_ch.col_a    <= cmd.ca;
    in_ch.row_b    <= cmd.rb;
    in_ch.col_b    <= cmd.cb;
    in_ch.color    <= cmd.color;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
  endtask

  task automatic drain();
    in_ch.valid <= 1'b0;
    @(posedge clk);
    while (sb.pending_replies.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_counts(logic [CFG_W-1:0] rows, logic [CFG_W-1:0] cols);
    drain();
    cfg_ch.valid <= 1'b1;
    cfg_ch.index <= CFG_ROWS;
    cfg_ch.data  <= rows;
    @(posedge clk);
    while (!cfg_ch.ready) @(posedge clk);
    cfg_ch.index <= CFG_COLS;
    cfg_ch.data  <= cols;
    @(posedge clk);
    while (!cfg_ch.ready) @(posedge clk);
    cfg_ch.valid <= 1'b0;
    @(posedge clk);
  endtask

  function automatic canvas_cmd_t mk(logic [REQ_W-1:0] req, int ra, int ca, int rb, int cb,
                                     int color);
    canvas_cmd_t c;
    c.req   = req;
    c.ra    = COORD_W'(ra);
    c.ca    = COORD_W'(ca);
    c.rb    = COORD_W'(rb);
    c.cb    = COORD_W'(cb);
    c.color = COLOR_W'(color);
    return c;
  endfunction

  function automatic logic [COORD_W-1:0] pick_coord(int unsigned lim);
    if ($urandom_range(0, 4) == 0 || lim == 0) return COORD_W'($urandom_range(0, 63));
    return COORD_W'($urandom_range(0, lim - 1));
  endfunction

  function automatic canvas_cmd_t random_cmd();
    canvas_cmd_t c;
    int unsigned w, rows, cols;
    rows = sb.rows_used();
    cols = sb.cols_used();
    w = $urandom_range(0, 99);
    if (w < 10) c.req = REQ_DOT;
    else if (w < 20) c.req = REQ_RECT;
    else if (w < 30) c.req = REQ_FILL;
    else if (w < 50) c.req = REQ_UNDO;
    else if (w < 65) c.req = REQ_REDO;
    else if (w < 95) c.req = REQ_READ;
    else c.req = $urandom_range(0, 1) ? REQ_SPARE_6 : REQ_SPARE_7;
    c.ra = pick_coord(rows);
    c.ca = pick_coord(cols);
    c.rb = pick_coord(rows);
    c.cb = pick_coord(cols);
    c.color = COLOR_W'(($urandom_range(0, 3) == 0) ? $urandom_range(0, 3)
                                                   : $urandom_range(0, 255));
    return c;
  endfunction

  initial begin
    logic [CFG_W-1:0] r, c;
    no_idle = 0;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    send_cmd(mk(REQ_UNDO, 0, 0, 0, 0, 0));
    send_cmd(mk(REQ_REDO, 0, 0, 0, 0, 0));
    send_cmd(mk(REQ_READ, 63, 63, 0, 0, 0));
    send_cmd(mk(REQ_SPARE_6, 63, 63, 63, 63, 255));
    send_cmd(mk(REQ_SPARE_7, 0, 0, 0, 0, 0));
    send_cmd(mk(REQ_DOT, 63, 63, 0, 0, 255));
    send_cmd(mk(REQ_READ, 63, 63, 0, 0, 0));
    send_cmd(mk(REQ_RECT, 63, 0, 0, 63, 8'h81));
    send_cmd(mk(REQ_FILL, 10, 10, 0, 0, 8'hAA));
    send_cmd(mk(REQ_FILL, 10, 10, 0, 0, 8'hAA));
    send_cmd(mk(REQ_UNDO, 0, 0, 0, 0, 0));
    send_cmd(mk(REQ_UNDO, 0, 0, 0, 0, 0));
    send_cmd(mk(REQ_REDO, 0, 0, 0, 0, 0));
    send_cmd(mk(REQ_READ, 10, 10, 0, 0, 0));

    write_counts(7'd0, 7'd127);
    send_cmd(mk(REQ_READ, 1, 0, 0, 0, 0));
    send_cmd(mk(REQ_READ, 0, 63, 0, 0, 0));
    send_cmd(mk(REQ_RECT, 0, 0, 1, 5, 3));
    send_cmd(mk(REQ_FILL, 0, 0, 0, 0, 0));

    write_counts(7'd8, 7'd8);
    send_cmd(mk(REQ_DOT, 8, 0, 0, 0, 1));
    send_cmd(mk(REQ_DOT, 0, 8, 0, 0, 1));
    send_cmd(mk(REQ_RECT, 1, 1, 6, 6, 0));
    send_cmd(mk(REQ_FILL, 3, 3, 0, 0, 8'h55));
    send_cmd(mk(REQ_READ, 7, 7, 0, 0, 0));

    for (int ph = 0; ph < 4; ph++) begin
      case ($urandom_range(0, 5))
        0: begin r = 7'd64; c = 7'd64; end
        1: begin r = 7'd127; c = 7'd0; end
        2: begin
          r = CFG_W'($urandom_range(0, 127));
          c = CFG_W'($urandom_range(0, 127));
        end
        default: begin
          r = CFG_W'($urandom_range(1, 8));
          c = CFG_W'($urandom_range(1, 8));
        end
      endcase
      write_counts(r, c);
      if (ph == 3) no_idle = 1;
      repeat (30) send_cmd(random_cmd());
    end

    drain();
    repeat (20) @(posedge clk);
    $display("covered %0d done, %0d out-of-range, %0d history-full replies",
             sb.n_done, sb.n_range, sb.n_full);
    $display("including %0d reads and %0d flood fills across several canvas sizes",
             sb.n_reads, sb.n_fills);
    if (sb.mismatches == 0 && sb.pending_replies.size() == 0) begin
      $display("Regression PASS");
    end else begin
      $display("%0d mismatches, %0d replies missing", sb.mismatches,
               sb.pending_replies.size());
      $display("Regression FAIL");
    end
    $finish;
  end
endmodule
